// ----- design/stis_pkg.sv -----
package stis_pkg;
  localparam int MAX_ELEMS = 64;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(MAX_ELEMS);
  localparam int CNT_W     = IDX_W + 1;
  localparam int TAG_W     = 6;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Datapath commands from the controller.
  typedef struct packed {
    logic             load;      // write incoming key at fill position
    logic             clr_fill;  // end of run
    logic             rd_en;     // read key/tag at rd_addr
    logic [IDX_W-1:0] rd_addr;
    logic             hold_k;    // capture read data as the element in hand
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_sel_k;  // 1 writes the element in hand, 0 the last read data
  } dp_cmd_t;

  typedef struct packed {
    cnt_t count;
    logic overflow;
    key_t rd_key;  // biased key, unsigned order
    key_t k_key;
  } dp_sts_t;
endpackage

// ----- design/shell_then_insertion_sorter_unit.sv -----
// Sorts up to 64 signed keys per run, ascending, each tagged with its arrival
// position. Keys are taken one per cycle until a transfer with in_is_last; further
// keys past capacity are dropped and flag out_truncated. The sort then runs on a
// one-read, one-write key/tag memory walked by a controller: gapped-insertion
// passes compare and shift with the gap, each binary search probe reads the
// midpoint and then compares, and each insertion shift reads one element and
// writes it one place up. Results stream out, each read and then held until the
// output register is free. Mode 1 (cfg_wdata under cfg_we) skips gapped passes.
module shell_then_insertion_sorter_unit
  import stis_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KEY_WIDTH-1:0] in_key_in,
  input  logic                 in_is_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KEY_WIDTH-1:0] out_key_out,
  output logic [TAG_W-1:0]     out_source_index,
  output logic                 out_last_out,
  output logic                 out_truncated
);
  localparam key_t SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  logic             mode_r;
  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [TAG_W-1:0] rd_tag;
  logic             fire, last, free;
  logic             ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) mode_r <= 1'b0;
    else if (cfg_we) mode_r <= cfg_wdata;
  end

  stis_datapath u_dp (
    .clk, .rst_n, .in_valid, .in_ready, .in_key_in,
    .cmd, .sts, .rd_tag
  );

  stis_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_is_last, .in_ready,
    .mode(mode_r), .sts, .cmd, .out_fire(fire), .out_last(last), .out_free(free)
  );

  assign free   = !ov_r || out_ready;
  assign ov_nxt = fire ? 1'b1 : (out_ready ? 1'b0 : ov_r);

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= ov_nxt;
    if (fire) begin
      out_key_out      <= sts.rd_key ^ SIGN;
      out_source_index <= rd_tag;
      out_last_out     <= last;
      out_truncated    <= sts.overflow;
    end
  end

  assign out_valid = ov_r;

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_out))
    else $error("result changed while stalled");
  a_no_input_emit: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !in_ready) else $error("emit while loading");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> free) else $error("result overwritten");
`endif
endmodule

// ----- design/stis_datapath.sv -----
module stis_datapath
  import stis_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [KEY_WIDTH-1:0] in_key_in,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts,
  output logic [TAG_W-1:0] rd_tag
);
  localparam key_t SIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  key_t             key_mem [MAX_ELEMS];
  logic [TAG_W-1:0] tag_mem [MAX_ELEMS];
  key_t             rd_key_r, k_key_r;
  logic [TAG_W-1:0] rd_tag_r, k_tag_r;
  cnt_t             count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             take;
  logic             full;

  assign take = in_valid && in_ready;
  assign full = (count_r == cnt_t'(MAX_ELEMS));

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.clr_fill) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (take) begin
      if (full) ovf_nxt = 1'b1;
      else count_nxt = count_r + cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !full) begin
      key_mem[count_r[IDX_W-1:0]] <= in_key_in ^ SIGN;
      tag_mem[count_r[IDX_W-1:0]] <= TAG_W'(count_r);
    end else if (cmd.wr_en) begin
      key_mem[cmd.wr_addr] <= cmd.wr_sel_k ? k_key_r : rd_key_r;
      tag_mem[cmd.wr_addr] <= cmd.wr_sel_k ? k_tag_r : rd_tag_r;
    end
    if (cmd.rd_en) begin
      rd_key_r <= key_mem[cmd.rd_addr];
      rd_tag_r <= tag_mem[cmd.rd_addr];
    end
    if (cmd.hold_k) begin
      k_key_r <= rd_key_r;
      k_tag_r <= rd_tag_r;
    end
  end

  assign sts.count    = count_r;
  assign sts.overflow = ovf_r;
  assign sts.rd_key   = rd_key_r;
  assign sts.k_key    = k_key_r;
  assign rd_tag       = rd_tag_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(MAX_ELEMS)) else $error("fill count beyond capacity");
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> full) else $error("overflow without full store");
  a_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> !take) else $error("sort write during load");
`endif
endmodule

// ----- design/stis_ctrl.sv -----
module stis_ctrl
  import stis_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_is_last,
  output logic    in_ready,
  input  logic    mode,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    out_fire,    // present read data as a result
  output logic    out_last,
  input  logic    out_free     // result register can take a result
);
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_GAPI  = 4'd1;   // compute largest gap
  localparam logic [3:0] S_GOUT  = 4'd2;   // read outer element
  localparam logic [3:0] S_GK    = 4'd3;   // hold it, read pos-gap
  localparam logic [3:0] S_GCMP  = 4'd4;   // compare / shift
  localparam logic [3:0] S_BOUT  = 4'd5;
  localparam logic [3:0] S_BK    = 4'd6;
  localparam logic [3:0] S_BCMP  = 4'd7;   // binary search step
  localparam logic [3:0] S_SHRD  = 4'd8;   // read j-1
  localparam logic [3:0] S_SHWR  = 4'd9;   // write j
  localparam logic [3:0] S_EMRD  = 4'd10;
  localparam logic [3:0] S_EMWT  = 4'd11;
  localparam logic [3:0] S_BS    = 4'd12;  // issue mid read

  logic [3:0] st_r, st_nxt;
  cnt_t n_r, n_nxt, gap_r, gap_nxt, outer_r, outer_nxt, pos_r, pos_nxt;
  cnt_t lo_r, lo_nxt, hi_r, hi_nxt;
  cnt_t mid;
  cnt_t n_div3;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  // n/3 for n up to MAX_ELEMS: reciprocal multiply with a small constant.
  assign n_div3 = cnt_t'((32'(n_r) * 32'd43691) >> 17);

  assign in_ready = (st_r == S_LOAD);

  always_comb begin
    st_nxt = st_r; n_nxt = n_r; gap_nxt = gap_r; outer_nxt = outer_r;
    pos_nxt = pos_r; lo_nxt = lo_r; hi_nxt = hi_r;
    cmd = '0;
    out_fire = 1'b0;
    out_last = 1'b0;
    case (st_r)
      S_LOAD: begin
        if (in_valid && in_is_last) begin
          n_nxt   = (sts.count == cnt_t'(MAX_ELEMS)) ? sts.count : sts.count + cnt_t'(1);
          gap_nxt = cnt_t'(1);
          st_nxt  = S_GAPI;
        end
      end
      S_GAPI: begin
        if (n_r <= cnt_t'(1)) begin
          outer_nxt = '0; st_nxt = S_EMRD;
        end else if (mode) begin
          outer_nxt = cnt_t'(1); st_nxt = S_BOUT;
        end else if (gap_r < n_div3) begin
          gap_nxt = cnt_t'(gap_r * cnt_t'(3) + cnt_t'(1));
        end else if (gap_r > cnt_t'(1)) begin
          outer_nxt = gap_r; st_nxt = S_GOUT;
        end else begin
          outer_nxt = cnt_t'(1); st_nxt = S_BOUT;
        end
      end
      S_GOUT: begin
        if (outer_r >= n_r) begin
          // (gap-1)/3 by reciprocal multiply, exact over the whole count range.
          gap_nxt = cnt_t'((14'(gap_r - cnt_t'(1)) * 14'd43) >> 7);
          if (gap_nxt > cnt_t'(1)) outer_nxt = gap_nxt;
          else begin
            outer_nxt = cnt_t'(1); st_nxt = S_BOUT;
          end
        end else begin
          cmd.rd_en = 1'b1; cmd.rd_addr = outer_r[IDX_W-1:0];
          pos_nxt = outer_r; st_nxt = S_GK;
        end
      end
      S_GK: begin
        cmd.hold_k = 1'b1;
        cmd.rd_en = 1'b1; cmd.rd_addr = IDX_W'(pos_r - gap_r);
        st_nxt = S_GCMP;
      end
      S_GCMP: begin
        if (pos_r >= gap_r && sts.rd_key > sts.k_key) begin
          cmd.wr_en = 1'b1; cmd.wr_addr = pos_r[IDX_W-1:0];
          pos_nxt = pos_r - gap_r;
          if (pos_nxt >= gap_r) begin
            cmd.rd_en = 1'b1; cmd.rd_addr = IDX_W'(pos_nxt - gap_r);
          end
        end else begin
          cmd.wr_en = 1'b1; cmd.wr_addr = pos_r[IDX_W-1:0]; cmd.wr_sel_k = 1'b1;
          outer_nxt = outer_r + cnt_t'(1); st_nxt = S_GOUT;
        end
      end
      S_BOUT: begin
        if (outer_r >= n_r) begin
          outer_nxt = '0; st_nxt = S_EMRD;
        end else begin
          cmd.rd_en = 1'b1; cmd.rd_addr = outer_r[IDX_W-1:0];
          lo_nxt = '0; hi_nxt = outer_r; st_nxt = S_BK;
        end
      end
      S_BK: begin
        cmd.hold_k = 1'b1; st_nxt = S_BS;
      end
      S_BS: begin
        if (lo_r < hi_r) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = mid[IDX_W-1:0]; st_nxt = S_BCMP;
        end else begin
          pos_nxt = outer_r; st_nxt = S_SHRD;
        end
      end
      S_BCMP: begin
        if (sts.rd_key > sts.k_key) hi_nxt = mid;
        else lo_nxt = mid + cnt_t'(1);
        st_nxt = S_BS;
      end
      S_SHRD: begin
        if (pos_r > lo_r) begin
          cmd.rd_en = 1'b1; cmd.rd_addr = IDX_W'(pos_r - cnt_t'(1)); st_nxt = S_SHWR;
        end else begin
          cmd.wr_en = 1'b1; cmd.wr_addr = lo_r[IDX_W-1:0]; cmd.wr_sel_k = 1'b1;
          outer_nxt = outer_r + cnt_t'(1); st_nxt = S_BOUT;
        end
      end
      S_SHWR: begin
        cmd.wr_en = 1'b1; cmd.wr_addr = pos_r[IDX_W-1:0];
        pos_nxt = pos_r - cnt_t'(1); st_nxt = S_SHRD;
      end
      S_EMRD: begin
        cmd.rd_en = 1'b1; cmd.rd_addr = outer_r[IDX_W-1:0]; st_nxt = S_EMWT;
      end
      S_EMWT: begin
        if (out_free) begin
          out_fire = 1'b1;
          out_last = (outer_r + cnt_t'(1) == n_r);
          outer_nxt = outer_r + cnt_t'(1);
          if (out_last) begin
            cmd.clr_fill = 1'b1; st_nxt = S_LOAD;
          end else st_nxt = S_EMRD;
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_LOAD;
    else st_r <= st_nxt;
    n_r <= n_nxt; gap_r <= gap_nxt; outer_r <= outer_nxt;
    pos_r <= pos_nxt; lo_r <= lo_nxt; hi_r <= hi_nxt;
  end

`ifndef NO_ASSERTIONS
  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en || cmd.rd_en) |-> st_r != S_LOAD) else $error("store access while loading");
  a_emit_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> $past(st_r) == S_EMRD || $past(st_r) == S_EMWT)
    else $error("result without a read");
  a_bs_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_BCMP |-> lo_r < hi_r) else $error("search range empty");
`endif
endmodule
